/* hw/rtl/asc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// asc_pkg
// shared types, field widths and command codes for the autoscaled strip chart
// ----------------------------------------------------------------------------
package asc_pkg;

  localparam int WIDTH_DEF       = 128;
  localparam int HEIGHT_DEF      = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int NUM_AXES    = 3;
  localparam int AXIS_BITS   = 2;
  localparam int RAW_BITS    = 16;
  localparam int COL_BITS    = 7;
  localparam int ROW_BITS    = 7;
  localparam int QUEUE_DEPTH = 2;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam logic [AXIS_BITS-1:0] AXIS_NONE = 2'd3;

  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_READ = 2'd1;
  localparam logic [1:0] OP_FLAT = 2'd2;

  typedef struct packed {
    logic [1:0]           op;
    logic [AXIS_BITS-1:0] axis;
    logic [COL_BITS-1:0]  col;
  } cmd_t;

endpackage
`default_nettype wire

/* hw/rtl/asc_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// asc_front
// accepts transactions, classifies them, saturates samples and queues commands
// ----------------------------------------------------------------------------
module asc_front #(
  parameter int WIDTH       = asc_pkg::WIDTH_DEF,
  parameter int SAMPLE_BITS = asc_pkg::SAMPLE_BITS_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire                                  in_req_type,
  input  wire  [asc_pkg::AXIS_BITS-1:0]        in_axis_sel,
  input  wire  signed [asc_pkg::RAW_BITS-1:0]  in_sample_raw,
  input  wire  [asc_pkg::COL_BITS-1:0]         in_column,
  output logic                                 q_valid,
  output asc_pkg::cmd_t                        q_cmd,
  output logic signed [SAMPLE_BITS-1:0]        q_sample,
  input  wire                                  q_pop
);

  localparam int DEPTH = asc_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic signed [32:0] SAT_MAX = 33'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [32:0] SAT_MIN = -SAT_MAX - 33'sd1;

  asc_pkg::cmd_t                 cmd_mem_r [DEPTH];
  logic signed [SAMPLE_BITS-1:0] smp_mem_r [DEPTH];
  logic [PTR_W-1:0]              wr_ptr_r;
  logic [PTR_W-1:0]              rd_ptr_r;
  logic [CNT_W-1:0]              count_r;
  logic [CNT_W-1:0]              count_nxt;

  logic signed [32:0]            raw_x;
  logic signed [32:0]            sat_x;
  logic                          col_ok;
  logic                          enq;
  asc_pkg::cmd_t                 cmd_in;

  // saturate to the stored sample width
  always_comb begin
    raw_x = 33'(in_sample_raw);
    if (raw_x > SAT_MAX) begin
      sat_x = SAT_MAX;
    end else if (raw_x < SAT_MIN) begin
      sat_x = SAT_MIN;
    end else begin
      sat_x = raw_x;
    end
  end

  // classify the transaction
  always_comb begin
    col_ok      = (32'(in_column) + 32'd1) < 32'(WIDTH);
    cmd_in.axis = in_axis_sel;
    cmd_in.col  = in_column;
    if (in_req_type == asc_pkg::REQ_PUSH) begin
      cmd_in.op = asc_pkg::OP_PUSH;
    end else if (in_axis_sel == asc_pkg::AXIS_NONE || !col_ok) begin
      cmd_in.op   = asc_pkg::OP_FLAT;
      cmd_in.axis = '0;
    end else begin
      cmd_in.op = asc_pkg::OP_READ;
    end
  end

  assign in_stall = (count_r == CNT_W'(DEPTH));
  // a push to the unused axis is dropped
  assign enq = in_valid && !in_stall &&
               !(in_req_type == asc_pkg::REQ_PUSH && in_axis_sel == asc_pkg::AXIS_NONE);

  assign q_valid  = (count_r != '0);
  assign q_cmd    = cmd_mem_r[rd_ptr_r];
  assign q_sample = smp_mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (enq && !q_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (!enq && q_pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (enq) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      cmd_mem_r[wr_ptr_r] <= cmd_in;
      smp_mem_r[wr_ptr_r] <= SAMPLE_BITS'(sat_x);
    end
  end

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> count_r != '0)
    else $error("command popped from empty queue");
`endif

endmodule
`default_nettype wire

/* hw/rtl/asc_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// asc_div
// ceiling of d*HEIGHT/range, one quotient bit per cycle
// ----------------------------------------------------------------------------
module asc_div #(
  parameter int HEIGHT      = asc_pkg::HEIGHT_DEF,
  parameter int SAMPLE_BITS = asc_pkg::SAMPLE_BITS_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   start,
  input  wire  [SAMPLE_BITS:0]                  d_in,
  input  wire  [SAMPLE_BITS:0]                  range_in,
  output logic                                  done,
  output logic [$clog2(HEIGHT + 1)-1:0]         q
);

  localparam int DW = SAMPLE_BITS + 1;
  localparam int QW = $clog2(HEIGHT + 1);
  localparam int NW = DW + QW;
  localparam int KW = $clog2(QW);

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_ADD  = 2'd1;
  localparam logic [1:0] D_ITER = 2'd2;

  logic [1:0]    state_r;
  logic [NW-1:0] prod_r;
  logic [DW-1:0] rng_r;
  logic [NW-1:0] rem_r;
  logic [NW-1:0] dv_r;
  logic [KW-1:0] k_r;
  logic [QW-1:0] q_r;
  logic          done_r;
  logic          fits;

  assign fits = (rem_r >= dv_r);
  assign done = done_r;
  assign q    = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        D_IDLE: begin
          if (start) begin
            state_r <= D_ADD;
          end
        end
        D_ADD: begin
          state_r <= D_ITER;
        end
        D_ITER: begin
          if (k_r == '0) begin
            state_r <= D_IDLE;
            done_r  <= 1'b1;
          end
        end
        default: begin
          state_r <= D_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      D_IDLE: begin
        if (start) begin
          prod_r <= NW'(d_in) * NW'(HEIGHT);
          rng_r  <= range_in;
          dv_r   <= NW'(range_in) << (QW - 1);
        end
      end
      D_ADD: begin
        // bias for the ceiling
        rem_r <= prod_r + NW'(rng_r) - NW'(1);
        k_r   <= KW'(QW - 1);
        q_r   <= '0;
      end
      D_ITER: begin
        if (fits) begin
          rem_r <= rem_r - dv_r;
        end
        q_r  <= {q_r[QW-2:0], fits};
        dv_r <= dv_r >> 1;
        k_r  <= k_r - KW'(1);
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> state_r == D_IDLE)
    else $error("divider started while busy");

  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> q_r <= QW'(HEIGHT))
    else $error("scaled quotient above height");
`endif

endmodule
`default_nettype wire

/* hw/rtl/asc_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// asc_back
// sample windows, min/max rescan and segment scaling with output register
// ----------------------------------------------------------------------------
module asc_back #(
  parameter int WIDTH       = asc_pkg::WIDTH_DEF,
  parameter int HEIGHT      = asc_pkg::HEIGHT_DEF,
  parameter int SAMPLE_BITS = asc_pkg::SAMPLE_BITS_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  q_valid,
  input  wire  asc_pkg::cmd_t                  q_cmd,
  input  wire  signed [SAMPLE_BITS-1:0]        q_sample,
  output logic                                 q_pop,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic [asc_pkg::ROW_BITS-1:0]         out_start_row,
  output logic [asc_pkg::ROW_BITS-1:0]         out_end_row,
  output logic                                 out_flat_segment
);

  localparam int SB = SAMPLE_BITS;
  localparam int DW = SB + 1;
  localparam int HW = $clog2(WIDTH);
  localparam int FW = $clog2(WIDTH + 1);
  localparam int PW = $clog2(2 * WIDTH + 1);
  localparam int QW = $clog2(HEIGHT + 1);
  localparam int NA = asc_pkg::NUM_AXES;
  localparam int RB = asc_pkg::ROW_BITS;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WRITE = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_RD0   = 3'd3;
  localparam logic [2:0] S_RD1   = 3'd4;
  localparam logic [2:0] S_DIV0  = 3'd5;
  localparam logic [2:0] S_DIV1  = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]                    state_r;
  logic [2:0]                    state_nxt;
  logic [asc_pkg::AXIS_BITS-1:0] ax_r;
  logic [asc_pkg::COL_BITS-1:0]  col_r;
  logic signed [SB-1:0]          sample_r;
  logic [HW-1:0]                 head_r [NA];
  logic [FW-1:0]                 fill_r [NA];
  logic signed [SB-1:0]          min_r  [NA];
  logic signed [SB-1:0]          max_r  [NA];
  logic signed [SB-1:0]          mem_r  [NA][WIDTH];
  logic signed [SB-1:0]          rd_data_r;
  logic                          rd_vld_r;
  logic [FW-1:0]                 scan_r;
  logic                          first_r;
  logic signed [SB-1:0]          lo_acc_r;
  logic signed [SB-1:0]          hi_acc_r;
  logic [QW-1:0]                 q0_r;
  logic [QW-1:0]                 q1_r;
  logic                          flat_r;
  logic                          out_valid_r;
  logic [RB-1:0]                 out_start_r;
  logic [RB-1:0]                 out_end_r;
  logic                          out_flat_r;

  logic [HW-1:0]                 cur_head;
  logic [FW-1:0]                 cur_fill;
  logic signed [SB-1:0]          cur_lo;
  logic signed [SB-1:0]          cur_hi;
  logic [PW-1:0]                 sum0;
  logic [PW-1:0]                 sum1;
  logic [PW-1:0]                 p0;
  logic [PW-1:0]                 p1;
  logic                          seg_ok;
  logic signed [SB-1:0]          lo_new;
  logic signed [SB-1:0]          hi_new;
  logic                          rd_en;
  logic [HW-1:0]                 rd_idx;
  logic                          wr_en;
  logic                          div_start;
  logic                          div_done;
  logic [QW-1:0]                 div_q;
  logic [DW-1:0]                 div_d;
  logic [DW-1:0]                 div_range;
  logic                          out_load;
  logic [QW-1:0]                 row0;
  logic [QW-1:0]                 row1;

  assign cur_head = head_r[ax_r];
  assign cur_fill = fill_r[ax_r];
  assign cur_lo   = min_r[ax_r];
  assign cur_hi   = max_r[ax_r];

  // column position in the circular window, oldest entry at the head once the window is full
  always_comb begin
    sum0   = PW'(cur_head) + PW'(col_r);
    sum1   = sum0 + PW'(1);
    p0     = (sum0 >= PW'(WIDTH)) ? sum0 - PW'(WIDTH) : sum0;
    p1     = (sum1 >= PW'(WIDTH)) ? sum1 - PW'(WIDTH) : sum1;
    seg_ok = (p0 < PW'(cur_fill)) && (p1 < PW'(cur_fill)) && (cur_hi > cur_lo);
  end

  always_comb begin
    lo_new = (first_r || rd_data_r < lo_acc_r) ? rd_data_r : lo_acc_r;
    hi_new = (first_r || rd_data_r > hi_acc_r) ? rd_data_r : hi_acc_r;
  end

  assign div_d     = DW'(DW'(rd_data_r) - DW'(cur_lo));
  assign div_range = DW'(DW'(cur_hi) - DW'(cur_lo));
  assign row0      = QW'(HEIGHT) - q0_r;
  assign row1      = QW'(HEIGHT) - q1_r;
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    rd_en     = 1'b0;
    rd_idx    = '0;
    wr_en     = 1'b0;
    div_start = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_cmd.op)
            asc_pkg::OP_PUSH: state_nxt = S_WRITE;
            asc_pkg::OP_READ: state_nxt = S_RD0;
            default:          state_nxt = S_OUT;
          endcase
        end
      end
      S_WRITE: begin
        wr_en     = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        rd_idx = scan_r[HW-1:0];
        rd_en  = (scan_r < cur_fill);
        if (!rd_en) begin
          state_nxt = S_IDLE;
        end
      end
      S_RD0: begin
        rd_idx = p0[HW-1:0];
        rd_en  = seg_ok;
        state_nxt = seg_ok ? S_RD1 : S_OUT;
      end
      S_RD1: begin
        rd_idx    = p1[HW-1:0];
        rd_en     = 1'b1;
        div_start = 1'b1;
        state_nxt = S_DIV0;
      end
      S_DIV0: begin
        if (div_done) begin
          div_start = 1'b1;
          state_nxt = S_DIV1;
        end
      end
      S_DIV1: begin
        if (div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NA; i++) begin
        head_r[i] <= '0;
        fill_r[i] <= '0;
        min_r[i]  <= '0;
        max_r[i]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_WRITE) begin
        head_r[ax_r] <= (cur_head == HW'(WIDTH - 1)) ? '0 : cur_head + HW'(1);
        if (cur_fill != FW'(WIDTH)) begin
          fill_r[ax_r] <= cur_fill + FW'(1);
        end
      end
      if (state_r == S_SCAN && !rd_en) begin
        min_r[ax_r] <= lo_new;
        max_r[ax_r] <= hi_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ax_r     <= q_cmd.axis;
      col_r    <= q_cmd.col;
      sample_r <= q_sample;
      flat_r   <= 1'b1;
    end
    if (state_r == S_WRITE) begin
      scan_r   <= '0;
      rd_vld_r <= 1'b0;
      first_r  <= 1'b1;
    end
    if (state_r == S_SCAN) begin
      rd_vld_r <= rd_en;
      if (rd_en) begin
        scan_r <= scan_r + FW'(1);
      end
      if (rd_vld_r) begin
        lo_acc_r <= lo_new;
        hi_acc_r <= hi_new;
        first_r  <= 1'b0;
      end
    end
    if (state_r == S_RD0 && seg_ok) begin
      flat_r <= 1'b0;
    end
    if (state_r == S_DIV0 && div_done) begin
      q0_r <= div_q;
    end
    if (state_r == S_DIV1 && div_done) begin
      q1_r <= div_q;
    end
    if (out_load) begin
      out_start_r <= flat_r ? RB'(HEIGHT) : RB'(row0);
      out_end_r   <= flat_r ? RB'(HEIGHT) : RB'(row1);
      out_flat_r  <= flat_r;
    end
  end

  // single-port window store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[ax_r][cur_head] <= sample_r;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[ax_r][rd_idx];
    end
  end

  asc_div #(
    .HEIGHT      (HEIGHT),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .d_in     (div_d),
    .range_in (div_range),
    .done     (div_done),
    .q        (div_q)
  );

  assign out_valid        = out_valid_r;
  assign out_start_row    = out_start_r;
  assign out_end_row      = out_end_r;
  assign out_flat_segment = out_flat_r;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r[0] <= FW'(WIDTH) && fill_r[1] <= FW'(WIDTH) && fill_r[2] <= FW'(WIDTH))
    else $error("window fill count above width");

  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_OUT)
    else $error("result presented outside output state");
`endif

endmodule
`default_nettype wire

/* hw/rtl/autoscaled_strip_chart.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// autoscaled_strip_chart
// three scrolling sample windows with autoscaled segment lookup
//
//   channel  ports                                           direction
//   in       in_valid in_stall in_req_type in_axis_sel       sink
//            in_sample_raw in_column
//   out      out_valid out_stall out_start_row out_end_row   source
//            out_flat_segment
//
// push: one window entry read per cycle for the min/max rescan of the filled
//   entries on the single-port sample store
// read: two passes through the shared one-bit-per-cycle divider; flat reads
//   skip the divider
// synchronous active-low reset; per-window fill counts stand in for valid marks
// a two-entry command queue and an output register let each side stall alone
// ----------------------------------------------------------------------------
module autoscaled_strip_chart #(
  parameter int WIDTH       = asc_pkg::WIDTH_DEF,
  parameter int HEIGHT      = asc_pkg::HEIGHT_DEF,
  parameter int SAMPLE_BITS = asc_pkg::SAMPLE_BITS_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire                                  in_req_type,
  input  wire  [asc_pkg::AXIS_BITS-1:0]        in_axis_sel,
  input  wire  signed [asc_pkg::RAW_BITS-1:0]  in_sample_raw,
  input  wire  [asc_pkg::COL_BITS-1:0]         in_column,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic [asc_pkg::ROW_BITS-1:0]         out_start_row,
  output logic [asc_pkg::ROW_BITS-1:0]         out_end_row,
  output logic                                 out_flat_segment
);

  logic                          q_valid;
  asc_pkg::cmd_t                 q_cmd;
  logic signed [SAMPLE_BITS-1:0] q_sample;
  logic                          q_pop;

  asc_front #(
    .WIDTH       (WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_axis_sel   (in_axis_sel),
    .in_sample_raw (in_sample_raw),
    .in_column     (in_column),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .q_sample      (q_sample),
    .q_pop         (q_pop)
  );

  asc_back #(
    .WIDTH       (WIDTH),
    .HEIGHT      (HEIGHT),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_cmd            (q_cmd),
    .q_sample         (q_sample),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_start_row    (out_start_row),
    .out_end_row      (out_end_row),
    .out_flat_segment (out_flat_segment)
  );

endmodule
`default_nettype wire
